// File: rtl/clt_pkg.sv
package clt_pkg;

  // buffer and argument limits
  localparam int BUF_DEPTH = 128;
  localparam int MAX_ARGS  = 16;

  // write position never passes BUF_DEPTH-1
  localparam int PosW = $clog2(BUF_DEPTH);
  localparam int TokW = $clog2(MAX_ARGS + 1);

  // fixed result field widths
  localparam int CharW   = 8;
  localparam int OffsetW = 7;
  localparam int CountW  = 5;

  // output queue, power of two, at least two entries
  localparam int FifoDepth = 4;
  localparam int FifoPtrW  = $clog2(FifoDepth);
  localparam int FifoCntW  = $clog2(FifoDepth + 1);

  localparam logic [CharW-1:0] CharNul       = 8'h00;
  localparam logic [CharW-1:0] CharSpace     = 8'h20;
  localparam logic [CharW-1:0] CharQuote     = 8'h22;
  localparam logic [CharW-1:0] CharBackslash = 8'h5C;

  typedef struct packed {
    logic            esc;
    logic            quotes;
    logic            expect_tok;
    logic            held;
    logic [PosW-1:0] wpos;
    logic [TokW-1:0] tokens;
    logic            ovf;
  } tok_state_t;

  localparam tok_state_t StateReset = '{
    esc: 1'b0, quotes: 1'b0, expect_tok: 1'b1, held: 1'b0,
    wpos: '0, tokens: '0, ovf: 1'b0
  };

  typedef struct packed {
    logic [CharW-1:0]   out_char;
    logic [OffsetW-1:0] buf_offset;
    logic               token_begin;
    logic [CountW-1:0]  arg_count;
    logic               line_done;
    logic               overflow;
  } result_t;

  // core -> queue push controls
  typedef struct packed {
    logic first;
    logic second;
  } push_t;

  // queue -> core status
  typedef struct packed {
    logic room2;
  } fifo_status_t;

endpackage

// File: rtl/clt_in_if.sv
interface clt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       line_end;

  modport source (output valid, output char_in, output line_end, input ready);
  modport sink (input valid, input char_in, input line_end, output ready);
endinterface

// File: rtl/clt_out_if.sv
interface clt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic [6:0] buf_offset;
  logic       token_begin;
  logic [4:0] arg_count;
  logic       line_done;
  logic       overflow;

  modport source (
    output valid, output out_char, output buf_offset, output token_begin,
    output arg_count, output line_done, output overflow, input ready
  );
  modport sink (
    input valid, input out_char, input buf_offset, input token_begin,
    input arg_count, input line_done, input overflow, output ready
  );
endinterface

// File: rtl/clt_core.sv
module clt_core (
  input  logic                  clk,
  input  logic                  rst,
  clt_in_if.sink                char_ch,
  input  clt_pkg::fifo_status_t status,
  output clt_pkg::push_t        push,
  output clt_pkg::result_t      res0,
  output clt_pkg::result_t      res1
);

  typedef struct packed {
    clt_pkg::tok_state_t st;
    logic                ok;
    clt_pkg::result_t    res;
  } store_ret_t;

  clt_pkg::tok_state_t st;
  clt_pkg::tok_state_t st_next;
  logic                v0;
  logic                v1;
  logic                acc;

  function automatic clt_pkg::result_t mk_result(clt_pkg::tok_state_t s,
                                                 logic [clt_pkg::CharW-1:0] ch,
                                                 logic begin_f, logic done);
    clt_pkg::result_t r;
    r.out_char    = ch;
    r.buf_offset  = clt_pkg::OffsetW'(s.wpos);
    r.token_begin = begin_f;
    r.arg_count   = clt_pkg::CountW'(s.tokens);
    r.line_done   = done;
    r.overflow    = s.ovf;
    return r;
  endfunction

  function automatic store_ret_t store_byte(clt_pkg::tok_state_t s,
                                            logic [clt_pkg::CharW-1:0] ch);
    store_ret_t r;
    logic       begin_f;
    r.st    = s;
    r.ok    = 1'b0;
    r.res   = '0;
    begin_f = 1'b0;
    if (s.wpos >= clt_pkg::PosW'(clt_pkg::BUF_DEPTH - 1)) begin
      r.st.ovf        = 1'b1;
      r.st.expect_tok = 1'b0;
    end else begin
      if (s.expect_tok) begin
        r.st.expect_tok = 1'b0;
        if (s.tokens < clt_pkg::TokW'(clt_pkg::MAX_ARGS)) begin
          r.st.tokens = s.tokens + clt_pkg::TokW'(1);
          begin_f     = 1'b1;
        end
      end
      r.res     = mk_result(r.st, ch, begin_f, 1'b0);
      r.ok      = 1'b1;
      r.st.wpos = s.wpos + clt_pkg::PosW'(1);
    end
    return r;
  endfunction

  function automatic store_ret_t store_sep(clt_pkg::tok_state_t s);
    store_ret_t r;
    r.st  = s;
    r.ok  = 1'b0;
    r.res = '0;
    if (s.wpos >= clt_pkg::PosW'(clt_pkg::BUF_DEPTH - 1)) begin
      r.st.ovf = 1'b1;
    end else begin
      r.res     = mk_result(s, clt_pkg::CharNul, 1'b0, 1'b0);
      r.ok      = 1'b1;
      r.st.wpos = s.wpos + clt_pkg::PosW'(1);
    end
    return r;
  endfunction

  function automatic store_ret_t handle_char(clt_pkg::tok_state_t s,
                                             logic [clt_pkg::CharW-1:0] c);
    store_ret_t r;
    r.st  = s;
    r.ok  = 1'b0;
    r.res = '0;
    if (c == clt_pkg::CharBackslash) begin
      if (s.quotes) begin
        r.st.held = 1'b1;
      end else if (s.esc) begin
        s.esc = 1'b0;
        r     = store_byte(s, c);
      end else begin
        r.st.esc = 1'b1;
      end
    end else if (c == clt_pkg::CharQuote) begin
      if (s.esc) begin
        s.esc = 1'b0;
        r     = store_byte(s, c);
      end else begin
        r.st.quotes = ~s.quotes;
      end
    end else if (c == clt_pkg::CharSpace) begin
      if (s.esc) begin
        s.esc = 1'b0;
        r     = store_byte(s, c);
      end else if (!s.quotes) begin
        if (!s.expect_tok) begin
          s.expect_tok = 1'b1;
          r            = store_sep(s);
        end
      end else begin
        r = store_byte(s, c);
      end
    end else begin
      r = store_byte(s, c);
    end
    return r;
  endfunction

  always_comb begin
    store_ret_t          sr;
    clt_pkg::tok_state_t s;
    clt_pkg::result_t    term;
    s    = st;
    v0   = 1'b0;
    v1   = 1'b0;
    res0 = '0;
    res1 = '0;
    sr   = '0;
    term = '0;
    if (char_ch.line_end) begin
      if (s.held) begin
        s.held = 1'b0;
        sr     = store_byte(s, clt_pkg::CharBackslash);
        s      = sr.st;
        v0     = sr.ok;
        res0   = sr.res;
      end
      term = mk_result(s, clt_pkg::CharNul, 1'b0, 1'b1);
      if (v0) begin
        v1   = 1'b1;
        res1 = term;
      end else begin
        v0   = 1'b1;
        res0 = term;
      end
      s = clt_pkg::StateReset;
    end else if (char_ch.char_in != clt_pkg::CharNul) begin
      if (s.held && char_ch.char_in == clt_pkg::CharQuote) begin
        // escaped quote inside quotes
        s.held = 1'b0;
        sr     = store_byte(s, char_ch.char_in);
        s      = sr.st;
        v0     = sr.ok;
        res0   = sr.res;
      end else begin
        if (s.held) begin
          s.held = 1'b0;
          sr     = store_byte(s, clt_pkg::CharBackslash);
          s      = sr.st;
          v0     = sr.ok;
          res0   = sr.res;
        end
        sr = handle_char(s, char_ch.char_in);
        s  = sr.st;
        if (sr.ok) begin
          if (v0) begin
            v1   = 1'b1;
            res1 = sr.res;
          end else begin
            v0   = 1'b1;
            res0 = sr.res;
          end
        end
      end
    end
    st_next = s;
  end

  assign char_ch.ready = status.room2;
  assign acc           = char_ch.valid && status.room2;
  assign push.first    = acc && v0;
  assign push.second   = acc && v1;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= clt_pkg::StateReset;
    end else if (acc) begin
      st <= st_next;
    end
  end

endmodule

// File: rtl/clt_out_fifo.sv
module clt_out_fifo (
  input  logic                  clk,
  input  logic                  rst,
  input  clt_pkg::push_t        push,
  input  clt_pkg::result_t      res0,
  input  clt_pkg::result_t      res1,
  output clt_pkg::fifo_status_t status,
  clt_out_if.source             result_ch
);

  clt_pkg::result_t              mem [clt_pkg::FifoDepth];
  logic [clt_pkg::FifoPtrW-1:0]  wptr;
  logic [clt_pkg::FifoPtrW-1:0]  rptr;
  logic [clt_pkg::FifoCntW-1:0]  count;
  logic                          pop;
  clt_pkg::result_t              head;

  assign pop          = result_ch.valid && result_ch.ready;
  assign status.room2 = count <= clt_pkg::FifoCntW'(clt_pkg::FifoDepth - 2);

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + clt_pkg::FifoPtrW'(push.first) + clt_pkg::FifoPtrW'(push.second);
      rptr  <= rptr + clt_pkg::FifoPtrW'(pop);
      count <= count + clt_pkg::FifoCntW'(push.first) + clt_pkg::FifoCntW'(push.second)
               - clt_pkg::FifoCntW'(pop);
    end
  end

  // second entry always lands after the first
  always_ff @(posedge clk) begin
    if (push.first) begin
      mem[wptr] <= res0;
    end
    if (push.second) begin
      mem[wptr + clt_pkg::FifoPtrW'(1)] <= res1;
    end
  end

  assign head                  = mem[rptr];
  assign result_ch.valid       = count != '0;
  assign result_ch.out_char    = head.out_char;
  assign result_ch.buf_offset  = head.buf_offset;
  assign result_ch.token_begin = head.token_begin;
  assign result_ch.arg_count   = head.arg_count;
  assign result_ch.line_done   = head.line_done;
  assign result_ch.overflow    = head.overflow;

endmodule

// File: rtl/command_line_tokenizer_unit.sv
// Channel    Dir  Payload                                          Accept
// char_ch    in   char_in[7:0], line_end                           valid && ready
// result_ch  out  out_char, buf_offset, token_begin, arg_count,    valid && ready
//                 line_done, overflow
//
// One character per cycle while char_ch.ready is high. Each character is
// decoded in the cycle it is taken and yields zero, one or two result
// items, written into a 4-entry output queue; the queue drains one item
// per cycle while result_ch.ready is high.
// char_ch.ready is high while the queue has room for two items; it depends
// only on registered queue occupancy, never combinationally on result_ch.ready.
// Synchronous active-high rst returns the tokenizer state to line start and
// empties the queue; no clearing pass.
module command_line_tokenizer_unit (
  input  logic      clk,
  input  logic      rst,
  clt_in_if.sink    char_ch,
  clt_out_if.source result_ch
);

  clt_pkg::push_t        push;
  clt_pkg::fifo_status_t status;
  clt_pkg::result_t      res0;
  clt_pkg::result_t      res1;

  // decode + quoting / escape state
  clt_core u_core (
    .clk    (clk),
    .rst    (rst),
    .char_ch(char_ch),
    .status (status),
    .push   (push),
    .res0   (res0),
    .res1   (res1)
  );

  // result queue, also the output register
  clt_out_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .res0     (res0),
    .res1     (res1),
    .status   (status),
    .result_ch(result_ch)
  );

`ifndef SYNTHESIS
  // second slot is only used behind the first
  a_push_order: assert property (@(posedge clk) disable iff (rst)
    push.second |-> push.first)
    else $error("second result pushed without first");

  // a line end always produces the terminator
  a_line_term: assert property (@(posedge clk) disable iff (rst)
    (char_ch.valid && char_ch.ready && char_ch.line_end) |-> push.first)
    else $error("line end accepted without terminator");

  // input backpressure only comes from a non-empty queue
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !char_ch.ready |-> result_ch.valid)
    else $error("input stalled with empty result queue");
`endif

endmodule
